/* src/wfc_pkg.sv */
// Shared types and constants for the wide float to fp32 converter.
// No dependencies; every module of the converter imports this package.
package wfc_pkg;

	// Value class codes, shared by input and result
	typedef enum logic [2:0] {
		CLS_ZERO   = 3'd0,
		CLS_SUB    = 3'd1,
		CLS_NORMAL = 3'd2,
		CLS_INF    = 3'd3,
		CLS_NAN    = 3'd4
	} class_t;

	// Conversion path picked by the front end
	typedef enum logic [2:0] {
		PATH_ZERO,
		PATH_SUB_IN,
		PATH_INF,
		PATH_NAN,
		PATH_NORM,
		PATH_OVF,
		PATH_DENORM
	} path_t;

	// Wide exponent bounds for the fp32 normal range (bias 2^31-1 against 127)
	localparam logic [31:0] EXP_NORM_MIN = 32'd2147483521; // unbiased -126
	localparam logic [31:0] EXP_NORM_MAX = 32'd2147483774; // unbiased 127
	localparam logic [31:0] EXP_REBIAS   = 32'd2147483520; // wide bias - 127
	localparam logic [31:0] SHIFT_BASE   = 32'd2147483529; // 8 + wide bias - 126

	localparam logic [7:0] FP_EXP_ONES = 8'hFF;
	localparam int         FRAC_W      = 31;
	localparam int         FP_FRAC_W   = 23;

	// Decoupling queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Classified operand handed from front to back
	typedef struct packed {
		logic                sign;
		path_t               path;
		class_t              icls;
		logic [7:0]          exp8;
		logic [4:0]          shamt;
		logic                flush;
		logic [FRAC_W-1:0]   frac;
	} item_t;

	// Queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* src/wfc_front.sv */
// Front end: accepts wide floats, classifies them and registers the result.
// Depends on wfc_pkg; pushes into wfc_queue.
module wfc_front
	import wfc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              sign_in,
	input  logic [31:0]       exponent_in,
	input  logic [30:0]       fraction_in,
	input  q_status_t         q_status,
	output logic              push,
	output item_t             push_item
);

	logic        valid_s1;
	item_t       item_s1;
	item_t       cls_item;
	logic        advance;
	logic        exp_zero;
	logic        exp_ones;
	logic        frac_zero;
	logic [31:0] rebias;
	logic [31:0] shift_full;

	// Classify the incoming operand
	always_comb begin
		exp_zero   = (exponent_in == '0);
		exp_ones   = &exponent_in;
		frac_zero  = (fraction_in == '0);
		rebias     = exponent_in - EXP_REBIAS;
		shift_full = SHIFT_BASE - exponent_in;

		cls_item.sign  = sign_in;
		cls_item.frac  = fraction_in;
		cls_item.exp8  = rebias[7:0];
		cls_item.shamt = shift_full[4:0];
		cls_item.flush = (shift_full[31:5] != '0);

		priority if (exp_zero) begin
			cls_item.path = frac_zero ? PATH_ZERO : PATH_SUB_IN;
			cls_item.icls = frac_zero ? CLS_ZERO : CLS_SUB;
		end else if (exp_ones) begin
			cls_item.path = frac_zero ? PATH_INF : PATH_NAN;
			cls_item.icls = frac_zero ? CLS_INF : CLS_NAN;
		end else if (exponent_in > EXP_NORM_MAX) begin
			cls_item.path = PATH_OVF;
			cls_item.icls = CLS_NORMAL;
		end else if (exponent_in >= EXP_NORM_MIN) begin
			cls_item.path = PATH_NORM;
			cls_item.icls = CLS_NORMAL;
		end else begin
			cls_item.path = PATH_DENORM;
			cls_item.icls = CLS_NORMAL;
		end
	end

	// Advance the stage unless its item is blocked by a full queue
	assign advance  = !valid_s1 || !q_status.full;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the classified payload on each transfer
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= cls_item;
		end
	end

	assign push      = valid_s1 && !q_status.full;
	assign push_item = item_s1;

endmodule

/* src/wfc_queue.sv */
// Short FIFO that decouples the classify front end from the rounding back end.
// Depends on wfc_pkg for the item type and depth.
module wfc_queue
	import wfc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     head_item,
	output q_status_t q_status
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign head_item      = slot_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* src/wfc_back.sv */
// Back end: rounds or denormalizes the queued item and holds the fp32 result.
// Depends on wfc_pkg; pops from wfc_queue.
module wfc_back
	import wfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  item_t       head_item,
	input  q_status_t   q_status,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] fp32_word,
	output logic [2:0]  input_class,
	output logic [2:0]  result_class
);

	logic        out_valid_q;
	logic [31:0] word_q;
	class_t      icls_q;
	class_t      rcls_q;

	logic [31:0] word_d;
	class_t      rcls_d;
	logic [24:0] norm_sum;
	logic [8:0]  norm_exp;
	logic [31:0] sig;
	logic [31:0] shifted;
	logic [31:0] lost_mask;
	logic        sticky;
	logic [23:0] den_q;
	logic [FP_FRAC_W-1:0] nan_frac;

	// Round, denormalize or pass through
	always_comb begin
		// Normal range, round away from zero
		norm_sum = {1'b0, 1'b1, head_item.frac[FRAC_W-1:8]} + 25'(|head_item.frac[7:0]);
		norm_exp = {1'b0, head_item.exp8} + 9'(norm_sum[24]);

		// Below normal range, sticky round-up
		sig       = {1'b1, head_item.frac};
		shifted   = sig >> head_item.shamt;
		lost_mask = (32'd1 << head_item.shamt) - 32'd1;
		sticky    = head_item.flush || ((sig & lost_mask) != '0);
		den_q     = (head_item.flush ? 24'd0 : shifted[23:0]) + 24'(sticky);

		// NaN keeps its top fraction bits, never all zero
		nan_frac = head_item.frac[FRAC_W-1:8];
		if (nan_frac == '0) begin
			nan_frac = 23'd1;
		end

		unique case (head_item.path)
			PATH_ZERO: begin
				word_d = {head_item.sign, 31'd0};
				rcls_d = CLS_ZERO;
			end
			PATH_SUB_IN: begin
				word_d = {head_item.sign, 31'd1};
				rcls_d = CLS_SUB;
			end
			PATH_INF, PATH_OVF: begin
				word_d = {head_item.sign, FP_EXP_ONES, 23'd0};
				rcls_d = CLS_INF;
			end
			PATH_NAN: begin
				word_d = {head_item.sign, FP_EXP_ONES, nan_frac};
				rcls_d = CLS_NAN;
			end
			PATH_NORM: begin
				if (norm_exp[7:0] == FP_EXP_ONES) begin
					word_d = {head_item.sign, FP_EXP_ONES, 23'd0};
					rcls_d = CLS_INF;
				end else begin
					word_d = {head_item.sign, norm_exp[7:0], norm_sum[FP_FRAC_W-1:0]};
					rcls_d = CLS_NORMAL;
				end
			end
			PATH_DENORM: begin
				word_d = {head_item.sign, 7'd0, den_q};
				rcls_d = den_q[23] ? CLS_NORMAL : CLS_SUB;
			end
			default: begin
				word_d = '0;
				rcls_d = CLS_ZERO;
			end
		endcase
	end

	// Pop when the output register is free or being drained
	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload on each pop
	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= word_d;
			icls_q <= head_item.icls;
			rcls_q <= rcls_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign fp32_word    = word_q;
	assign input_class  = icls_q;
	assign result_class = rcls_q;

endmodule

/* src/wide_float_to_fp32_convert.sv */
// Channel  | Handshake          | Payload
// input    | in_valid/in_stall  | sign_in, exponent_in[31:0], fraction_in[30:0]
// output   | out_valid/out_stall| fp32_word[31:0], input_class[2:0], result_class[2:0]
//
// One operand per cycle sustained while out_stall stays low; an operand passes the classify
// register, the queue slot, then rounding into the output register before out_valid.
// The four-entry queue between classify and rounding absorbs output stalls;
// in_stall rises only once the queue is full and the classify stage is occupied.
// Asynchronous active-low reset empties all stages; there is no clearing pass.
// Top level of the wide float to fp32 converter; depends on wfc_pkg and the
// wfc_front, wfc_queue and wfc_back modules.
module wide_float_to_fp32_convert
	import wfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        sign_in,
	input  logic [31:0] exponent_in,
	input  logic [30:0] fraction_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] fp32_word,
	output logic [2:0]  input_class,
	output logic [2:0]  result_class
);

	q_status_t q_status;
	logic      push;
	logic      pop;
	item_t     push_item;
	item_t     head_item;

	// Classify and register incoming operands
	wfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sign_in     (sign_in),
		.exponent_in (exponent_in),
		.fraction_in (fraction_in),
		.q_status    (q_status),
		.push        (push),
		.push_item   (push_item)
	);

	// Decouple front and back
	wfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_status  (q_status)
	);

	// Round and hold results
	wfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (head_item),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fp32_word    (fp32_word),
		.input_class  (input_class),
		.result_class (result_class)
	);

	// NaN in and NaN out go together
	a_nan_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((input_class == CLS_NAN) == (result_class == CLS_NAN)))
		else $error("NaN class mismatch between input and result");

	// Infinity result carries the infinity encoding
	a_inf_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_class == CLS_INF) |->
		(fp32_word[30:23] == FP_EXP_ONES && fp32_word[22:0] == '0))
		else $error("infinity result with wrong encoding");

	// Normal result has an exponent inside the finite range
	a_norm_exp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_class == CLS_NORMAL) |->
		(fp32_word[30:23] != '0 && fp32_word[30:23] != FP_EXP_ONES))
		else $error("normal result with reserved exponent");

	// Zero input yields signed zero
	a_zero_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && input_class == CLS_ZERO) |->
		(fp32_word[30:0] == '0 && result_class == CLS_ZERO))
		else $error("zero input did not give zero");

endmodule

/* test/wide_float_to_fp32_convert_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for wide_float_to_fp32_convert: corner table, then random operands.
// Expected results: typed corner rows, else an in-bench narrowing model; depends on wfc_pkg.
module wide_float_to_fp32_convert_tb;
	import wfc_pkg::*;

	localparam longint WIDE_BIAS     = 2147483647;
	localparam longint FP32_BIAS     = 127;
	localparam longint FP32_EMIN     = -126;
	localparam longint FP32_EMAX     = 127;
	localparam logic [7:0] FP32_EXP_ONES = 8'hFF;
	localparam int     PHASE_ITEMS   = 200;
	localparam int     DRAIN_CYCLES  = 10;
	localparam int     WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [31:0] word;
		class_t      icls;
		class_t      rcls;
	} fp32_result_t;

	// One corner operand; the result is typed in only where it is obvious
	typedef struct {
		logic         sign;
		logic [31:0]  expo;
		logic [30:0]  frac;
		bit           typed;
		logic [31:0]  word;
		class_t       icls;
		class_t       rcls;
	} corner_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        sign_in;
	logic [31:0] exponent_in;
	logic [30:0] fraction_in;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] fp32_word;
	logic [2:0]  input_class;
	logic [2:0]  result_class;

	fp32_result_t pending_fp32[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	corner_t corner_rows [0:24] = '{
		'{1'b0, 32'h0000_0000, 31'h0000_0000, 1'b1, 32'h0000_0000, CLS_ZERO, CLS_ZERO},
		'{1'b1, 32'h0000_0000, 31'h0000_0000, 1'b1, 32'h8000_0000, CLS_ZERO, CLS_ZERO},
		'{1'b0, 32'h0000_0000, 31'h0000_0001, 1'b1, 32'h0000_0001, CLS_SUB, CLS_SUB},
		'{1'b1, 32'h0000_0000, 31'h7FFF_FFFF, 1'b1, 32'h8000_0001, CLS_SUB, CLS_SUB},
		'{1'b0, 32'hFFFF_FFFF, 31'h0000_0000, 1'b1, 32'h7F80_0000, CLS_INF, CLS_INF},
		'{1'b1, 32'hFFFF_FFFF, 31'h0000_0000, 1'b1, 32'hFF80_0000, CLS_INF, CLS_INF},
		// NaN payloads that vanish in the top 23 bits force bit 0
		'{1'b0, 32'hFFFF_FFFF, 31'h0000_0001, 1'b1, 32'h7F80_0001, CLS_NAN, CLS_NAN},
		'{1'b1, 32'hFFFF_FFFF, 31'h0000_00FF, 1'b1, 32'hFF80_0001, CLS_NAN, CLS_NAN},
		'{1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, CLS_NAN, CLS_NAN},
		'{1'b0, 32'hFFFF_FFFF, 31'h4000_0000, 1'b1, 32'h7FC0_0000, CLS_NAN, CLS_NAN},
		// one, and one with a single sticky bit
		'{1'b0, 32'h7FFF_FFFF, 31'h0000_0000, 1'b1, 32'h3F80_0000, CLS_NORMAL, CLS_NORMAL},
		'{1'b1, 32'h7FFF_FFFF, 31'h0000_0001, 1'b1, 32'hBF80_0001, CLS_NORMAL, CLS_NORMAL},
		// top of the fp32 range and overflow
		'{1'b0, 32'h8000_007E, 31'h0000_0000, 1'b1, 32'h7F00_0000, CLS_NORMAL, CLS_NORMAL},
		'{1'b0, 32'h8000_007E, 31'h7FFF_FFFF, 1'b1, 32'h7F80_0000, CLS_NORMAL, CLS_INF},
		'{1'b1, 32'h8000_007F, 31'h0000_0000, 1'b1, 32'hFF80_0000, CLS_NORMAL, CLS_INF},
		'{1'b0, 32'hFFFF_FFFE, 31'h0000_0000, 1'b1, 32'h7F80_0000, CLS_NORMAL, CLS_INF},
		// bottom of the normal range and denormalization
		'{1'b0, 32'h7FFF_FF81, 31'h0000_0000, 1'b1, 32'h0080_0000, CLS_NORMAL, CLS_NORMAL},
		'{1'b0, 32'h7FFF_FF81, 31'h7FFF_FFFF, 1'b1, 32'h0100_0000, CLS_NORMAL, CLS_NORMAL},
		'{1'b0, 32'h7FFF_FF80, 31'h0000_0000, 1'b1, 32'h0040_0000, CLS_NORMAL, CLS_SUB},
		'{1'b0, 32'h7FFF_FF80, 31'h7FFF_FFFF, 1'b1, 32'h0080_0000, CLS_NORMAL, CLS_NORMAL},
		'{1'b0, 32'h7FFF_FF6A, 31'h0000_0000, 1'b1, 32'h0000_0001, CLS_NORMAL, CLS_SUB},
		'{1'b0, 32'h7FFF_FF69, 31'h0000_0000, 1'b1, 32'h0000_0001, CLS_NORMAL, CLS_SUB},
		'{1'b1, 32'h0000_0001, 31'h0000_0000, 1'b1, 32'h8000_0001, CLS_NORMAL, CLS_SUB},
		'{1'b0, 32'h7FFF_FF90, 31'h1234_5678, 1'b0, 32'h0000_0000, CLS_ZERO, CLS_ZERO},
		'{1'b1, 32'h8000_0010, 31'h5555_5555, 1'b0, 32'h0000_0000, CLS_ZERO, CLS_ZERO}
	};

	wide_float_to_fp32_convert dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sign_in      (sign_in),
		.exponent_in  (exponent_in),
		.fraction_in  (fraction_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fp32_word    (fp32_word),
		.input_class  (input_class),
		.result_class (result_class)
	);

	// Narrow one wide float to fp32, rounding away from zero
	function automatic fp32_result_t narrow_to_fp32(logic s, logic [31:0] e_bits,
			logic [30:0] f);
		fp32_result_t r;
		longint unb;
		longint shift;
		logic [31:0] sig;
		logic [31:0] q;
		logic [22:0] kept;
		logic sticky;
		sig = {1'b1, f};
		unb = e_bits;
		unb = unb - WIDE_BIAS;
		if (e_bits == '0) begin
			r.icls = (f == '0) ? CLS_ZERO : CLS_SUB;
			r.rcls = r.icls;
			r.word = {s, 30'd0, f != '0};
		end else if (e_bits == '1) begin
			kept = f[30:8];
			if (kept == '0)
				kept = 23'd1;
			r.icls = (f == '0) ? CLS_INF : CLS_NAN;
			r.rcls = r.icls;
			r.word = {s, FP32_EXP_ONES, (f == '0) ? 23'd0 : kept};
		end else if (unb >= FP32_EMIN) begin
			r.icls = CLS_NORMAL;
			q = {8'd0, sig[31:8]} + 32'(sig[7:0] != 8'd0);
			// carry out of rounding bumps the exponent
			if (q[24]) begin
				q = q >> 1;
				unb = unb + 1;
			end
			if (unb > FP32_EMAX) begin
				r.rcls = CLS_INF;
				r.word = {s, FP32_EXP_ONES, 23'd0};
			end else begin
				r.rcls = CLS_NORMAL;
				r.word = {s, 8'(unb + FP32_BIAS), q[22:0]};
			end
		end else begin
			r.icls = CLS_NORMAL;
			shift = 8 + FP32_EMIN - unb;
			if (shift >= 32) begin
				q = '0;
				sticky = 1'b1;
			end else begin
				q = sig >> shift;
				sticky = (sig & ((32'd1 << shift) - 32'd1)) != '0;
			end
			q = q + 32'(sticky);
			r.rcls = (q >= 32'h0080_0000) ? CLS_NORMAL : CLS_SUB;
			r.word = {s, q[30:0]};
		end
		return r;
	endfunction

	// Draw an operand biased toward the interesting exponent bands
	task automatic pick_wide_operand(output logic s, output logic [31:0] e,
			output logic [30:0] f);
		s = 1'($urandom);
		case ($urandom_range(19))
			0:       e = '0;
			1:       e = '1;
			2, 3, 4, 5, 6, 7, 8:
				e = 32'h7FFF_FF81 + $urandom_range(253);
			9, 10, 11, 12:
				e = 32'h7FFF_FF81 - $urandom_range(40);
			13, 14:  e = 32'h8000_007A + $urandom_range(8);
			15, 16:  e = 32'h7FFF_FF68 + $urandom_range(4);
			default: e = $urandom;
		endcase
		case ($urandom_range(7))
			0:       f = '0;
			1:       f = '1;
			2:       f = 31'($urandom_range(255));
			3:       f = {23'($urandom), 8'd0};
			4:       f = {23'h7F_FFFF, 8'($urandom)};
			default: f = 31'($urandom);
		endcase
	endtask

	// Offer one operand, idling first at the current rate; return on its transfer
	task automatic offer_operand(logic s, logic [31:0] e, logic [30:0] f, bit typed,
			fp32_result_t typed_result);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		sign_in     <= s;
		exponent_in <= e;
		fraction_in <= f;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		pending_fp32.push_back(typed ? typed_result : narrow_to_fp32(s, e, f));
	endtask

	// Hold the sender until every expected result has come back
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_fp32.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver stalls at the current rate
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Check each output transfer against the oldest expectation; watch for hangs
	always @(posedge clk) begin
		fp32_result_t want;
		if (arst_n) begin
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (out_valid === 1'b1 && !out_stall) begin
				if (pending_fp32.size() == 0) begin
					$display("%0t: unexpected result word %h classes %0d/%0d", $time,
						fp32_word, input_class, result_class);
					mismatch_count++;
				end else begin
					want = pending_fp32.pop_front();
					if (fp32_word !== want.word) begin
						$display("%0t: fp32_word expected %h, got %h", $time,
							want.word, fp32_word);
						mismatch_count++;
					end
					if (input_class !== want.icls) begin
						$display("%0t: input_class expected %0d, got %0d", $time,
							want.icls, input_class);
						mismatch_count++;
					end
					if (result_class !== want.rcls) begin
						$display("%0t: result_class expected %0d, got %0d", $time,
							want.rcls, result_class);
						mismatch_count++;
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding",
					$time, idle_cycles, pending_fp32.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int send_pcts [0:2];
		int recv_pcts [0:2];
		logic        s;
		logic [31:0] e;
		logic [30:0] f;
		fp32_result_t typed_result;
		send_pcts = '{9, 50, 0};
		recv_pcts = '{50, 9, 0};
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		sign_in     <= 1'b0;
		exponent_in <= '0;
		fraction_in <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the corner table
		send_idle_pct  = send_pcts[0];
		recv_stall_pct = recv_pcts[0];
		foreach (corner_rows[i]) begin
			typed_result.word = corner_rows[i].word;
			typed_result.icls = corner_rows[i].icls;
			typed_result.rcls = corner_rows[i].rcls;
			offer_operand(corner_rows[i].sign, corner_rows[i].expo, corner_rows[i].frac,
				corner_rows[i].typed, typed_result);
		end
		wait_for_drain();

		// Random operands under each idling mix, draining between mixes
		for (int p = 0; p < 3; p++) begin
			send_idle_pct  = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick_wide_operand(s, e, f);
				offer_operand(s, e, f, 1'b0, typed_result);
			end
			wait_for_drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
